[design/epr_pkg.sv]
// Shared types and constants of the entropy pool ring.
`default_nettype none
package epr_pkg;

    localparam int POOL_BYTES_DEF = 64;
    localparam int BITS_PER_BYTE  = 8;
    localparam logic [6:0] MAX_READ = 7'd64;

    // operation codes on the input channel
    localparam logic [2:0] OP_STORE     = 3'd0;
    localparam logic [2:0] OP_READ_ONE  = 3'd1;
    localparam logic [2:0] OP_READ_MANY = 3'd2;
    localparam logic [2:0] OP_DISCARD   = 3'd3;
    localparam logic [2:0] OP_FLUSH     = 3'd4;

    // register indexes
    localparam logic CFG_POOL_SIZE = 1'b0;

    typedef enum logic [2:0] {
        K_STORE,
        K_READ_ONE,
        K_READ_MANY,
        K_DISCARD,
        K_FLUSH,
        K_NONE
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] bits;
        logic [4:0]  count;
        logic [6:0]  req;
    } t_cmd;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic [6:0] amount;
        logic [6:0] bytes_used;
        logic       is_full;
        logic       last;
    } t_result;

endpackage
`default_nettype wire

[design/epr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module epr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[design/epr_front.sv]
// Input stage: accepts items, decodes the operation and trims the bit count.
`default_nettype none
module epr_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [2:0]    i_operation,
    input  wire logic [31:0]   i_entropy_bits,
    input  wire logic [5:0]    i_bit_count,
    input  wire logic [6:0]    i_byte_count,
    input  wire logic          i_clearing,
    input  wire logic          i_q_full,
    output logic               o_push,
    output epr_pkg::t_cmd      o_cmd
);
    import epr_pkg::*;

    logic  r_valid, n_valid;
    t_cmd  r_cmd, n_cmd;
    t_kind w_kind;
    logic  w_accept;

    always_comb begin
        case (i_operation)
            OP_STORE:     w_kind = K_STORE;
            OP_READ_ONE:  w_kind = K_READ_ONE;
            OP_READ_MANY: w_kind = K_READ_MANY;
            OP_DISCARD:   w_kind = K_DISCARD;
            OP_FLUSH:     w_kind = K_FLUSH;
            default:      w_kind = K_NONE;
        endcase
    end

    assign o_in_stall = i_clearing | (r_valid & i_q_full);
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign o_push     = r_valid & ~i_q_full;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (w_accept) begin
            n_valid     = 1'b1;
            n_cmd.kind  = w_kind;
            n_cmd.bits  = i_entropy_bits;
            n_cmd.count = i_bit_count[4:0];
            n_cmd.req   = i_byte_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end
endmodule
`default_nettype wire

[design/epr_queue.sv]
// Two-entry command queue between the input stage and the ring engine.
`default_nettype none
module epr_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire epr_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output epr_pkg::t_cmd      o_cmd,
    output logic               o_empty
);
    import epr_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end
endmodule
`default_nettype wire

[design/epr_back.sv]
// Ring engine: pointers, byte store sequencing and the result register.
`default_nettype none
module epr_back #(
    parameter int POOL_BYTES = epr_pkg::POOL_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [6:0]    i_pool_size,
    input  wire logic          i_cfg_clr,
    input  wire epr_pkg::t_cmd i_cmd,
    input  wire logic          i_q_empty,
    output logic               o_pop,
    output logic               o_clearing,
    input  wire logic          i_out_stall,
    output logic               o_out_valid,
    output epr_pkg::t_result   o_res
);
    import epr_pkg::*;

    localparam int IW = (POOL_BYTES > 1) ? $clog2(POOL_BYTES) : 1;
    localparam int SW = ((IW > 7) ? IW : 7) + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ST_RD,
        S_ST_WR,
        S_RD_ADDR,
        S_RD_DATA,
        S_EMIT
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_head, n_head, r_tail, n_tail, r_clr, n_clr;
    logic          r_full, n_full;
    logic [2:0]    r_bitpos, n_bitpos;
    logic [31:0]   r_bits, n_bits;
    logic [4:0]    r_rem, n_rem;
    logic [6:0]    r_amount, n_amount, r_left, n_left;
    logic          r_out_valid, n_out_valid;
    t_result       r_out, n_out;

    logic          w_we;
    logic [IW-1:0] w_waddr, w_raddr;
    logic [7:0]    w_wdata, w_rdata, w_mask, w_chunk;
    logic [3:0]    w_room, w_take;
    logic          w_out_free, w_wrap;
    logic [6:0]    w_used, w_n;
    logic [IW-1:0] w_tail1, w_head1;

    function automatic logic [6:0] f_used(logic [IW-1:0] h, logic [IW-1:0] t, logic f,
                                          logic [6:0] ps);
        logic [SW-1:0] hs, ts;
        hs = SW'(h);
        ts = SW'(t);
        if (h == t && !f) begin
            return 7'd0;
        end
        if (t > h) begin
            return 7'(ts - hs);
        end
        return 7'(SW'(ps) - (hs - ts));
    endfunction

    function automatic logic [IW-1:0] f_adv(logic [IW-1:0] idx, logic [6:0] by,
                                            logic [6:0] ps);
        logic [SW-1:0] s;
        s = SW'(idx) + SW'(by);
        if (s >= SW'(ps)) begin
            s = s - SW'(ps);
        end
        return IW'(s);
    endfunction

    epr_ram #(.WIDTH(BITS_PER_BYTE), .DEPTH(POOL_BYTES)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign w_used     = f_used(r_head, r_tail, r_full, i_pool_size);
    assign w_raddr    = (r_state == S_ST_RD || r_state == S_ST_WR) ? r_tail : r_head;

    // bits that fit in the current byte, and their placement
    assign w_room  = 4'd8 - {1'b0, r_bitpos};
    assign w_take  = ({4'd0, r_rem} < {4'd0, w_room}) ? r_rem[3:0] : w_room;
    assign w_mask  = 8'((9'd1 << w_take) - 9'd1);
    assign w_chunk = (r_bits[7:0] & w_mask) << r_bitpos;
    assign w_wrap  = ({1'b0, r_bitpos} + w_take) == 4'd8;
    assign w_tail1 = f_adv(r_tail, 7'd1, i_pool_size);
    assign w_head1 = f_adv(r_head, 7'd1, i_pool_size);
    assign w_n     = ({2'b0, i_cmd.req} < {2'b0, w_used}) ? i_cmd.req : w_used;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_tail;
        w_wdata = w_rdata ^ w_chunk;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = 8'd0;
            end
            S_ST_WR: w_we = 1'b1;
            default: w_we = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_full      = r_full;
        n_bitpos    = r_bitpos;
        n_clr       = r_clr;
        n_bits      = r_bits;
        n_rem       = r_rem;
        n_amount    = r_amount;
        n_left      = r_left;
        n_out_valid = r_out_valid & i_out_stall;
        n_out       = r_out;
        o_pop       = 1'b0;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + IW'(1);
                if (r_clr == IW'(POOL_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop    = 1'b1;
                    n_bits   = i_cmd.bits;
                    n_rem    = i_cmd.count;
                    n_amount = 7'd0;
                    n_state  = S_EMIT;
                    case (i_cmd.kind)
                        K_STORE: begin
                            n_amount = {2'b0, i_cmd.count};
                            if (i_cmd.count != 5'd0) begin
                                n_state = S_ST_RD;
                            end
                        end
                        K_READ_ONE: begin
                            if (w_used != 7'd0) begin
                                n_amount = 7'd1;
                                n_left   = 7'd1;
                                n_state  = S_RD_ADDR;
                            end
                        end
                        K_READ_MANY: begin
                            if (w_n != 7'd0) begin
                                n_amount = (w_n > MAX_READ) ? MAX_READ : w_n;
                                n_left   = n_amount;
                                n_state  = S_RD_ADDR;
                            end
                        end
                        K_DISCARD: begin
                            n_amount = w_n;
                            n_head   = f_adv(r_head, w_n, i_pool_size);
                            if (w_n != 7'd0) begin
                                n_full = 1'b0;
                            end
                        end
                        K_FLUSH: begin
                            n_head = '0;
                            n_tail = '0;
                            n_full = 1'b0;
                        end
                        default: n_amount = 7'd0;
                    endcase
                end
            end
            S_ST_RD: n_state = S_ST_WR;
            S_ST_WR: begin
                n_bits   = r_bits >> w_take;
                n_rem    = r_rem - {1'b0, w_take};
                n_bitpos = 3'(r_bitpos + w_take[2:0]);
                if (w_wrap) begin
                    if (r_full) begin
                        n_head = w_head1;
                    end
                    n_tail = w_tail1;
                    n_full = (w_tail1 == (r_full ? w_head1 : r_head));
                end
                n_state = (r_rem == {1'b0, w_take}) ? S_EMIT : S_ST_RD;
            end
            S_RD_ADDR: n_state = S_RD_DATA;
            S_RD_DATA: begin
                if (w_out_free) begin
                    n_head           = w_head1;
                    n_full           = 1'b0;
                    n_left           = r_left - 7'd1;
                    n_out_valid      = 1'b1;
                    n_out.data_byte  = w_rdata;
                    n_out.data_valid = 1'b1;
                    n_out.amount     = r_amount;
                    n_out.bytes_used = f_used(w_head1, r_tail, 1'b0, i_pool_size);
                    n_out.is_full    = 1'b0;
                    n_out.last       = (r_left == 7'd1);
                    n_state          = (r_left == 7'd1) ? S_IDLE : S_RD_ADDR;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.data_byte  = 8'd0;
                    n_out.data_valid = 1'b0;
                    n_out.amount     = r_amount;
                    n_out.bytes_used = w_used;
                    n_out.is_full    = r_full;
                    n_out.last       = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // size write: drop pointers and bit position
        if (i_cfg_clr) begin
            n_head   = '0;
            n_tail   = '0;
            n_full   = 1'b0;
            n_bitpos = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_head      <= '0;
            r_tail      <= '0;
            r_full      <= 1'b0;
            r_bitpos    <= 3'd0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_full      <= n_full;
            r_bitpos    <= n_bitpos;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_bits   <= n_bits;
        r_rem    <= n_rem;
        r_amount <= n_amount;
        r_left   <= n_left;
        r_out    <= n_out;
    end

    assign o_clearing  = (r_state == S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;
endmodule
`default_nettype wire

[design/entropy_pool_ring.sv]
// Entropy pool ring: top level with configuration port, front, queue and engine.
// Store items XOR up to 31 bits into a byte ring; reads and discard act at the
// head and flush empties the ring. Each ring byte touched by a store is read and
// then written back on the single store RAM; each byte read out takes one read
// through the RAM's read port. A two-entry queue lets items be accepted while the
// engine works.
// After reset the store is zeroed by a pass over all POOL_BYTES bytes, during which
// input is stalled; configuration writes are taken at any time. Write pool_size (byte
// address 0, 1 to 64, out of range values clamped) only while the block is idle.
`default_nettype none
module entropy_pool_ring #(
    parameter int POOL_BYTES = epr_pkg::POOL_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_operation,
    input  wire logic [31:0] i_entropy_bits,
    input  wire logic [5:0]  i_bit_count,
    input  wire logic [6:0]  i_byte_count,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_data_byte,
    output logic             o_data_valid,
    output logic [6:0]       o_amount,
    output logic [6:0]       o_bytes_used,
    output logic             o_is_full,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import epr_pkg::*;

    localparam logic [6:0] SIZE_RESET = (POOL_BYTES > 127) ? 7'd127 : 7'(POOL_BYTES);

    logic       r_pool_size;
    logic [6:0] r_size, w_size;
    logic       w_cfg_wr;
    logic       w_push, w_q_full, w_pop, w_q_empty, w_clearing;
    t_cmd       w_front_cmd, w_q_cmd;
    t_result    w_res;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & (paddr[2] == CFG_POOL_SIZE);
    assign prdata   = (paddr[2] == CFG_POOL_SIZE) ? {25'd0, r_size} : 32'd0;

    always_comb begin
        w_size = pwdata[6:0];
        if (w_size == 7'd0) begin
            w_size = 7'd1;
        end else if (32'(w_size) > POOL_BYTES) begin
            w_size = SIZE_RESET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= SIZE_RESET;
            r_pool_size <= 1'b0;
        end else begin
            r_pool_size <= w_cfg_wr;
            if (w_cfg_wr) begin
                r_size <= w_size;
            end
        end
    end

    epr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_entropy_bits (i_entropy_bits),
        .i_bit_count    (i_bit_count),
        .i_byte_count   (i_byte_count),
        .i_clearing     (w_clearing),
        .i_q_full       (w_q_full),
        .o_push         (w_push),
        .o_cmd          (w_front_cmd)
    );

    epr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd),
        .o_empty (w_q_empty)
    );

    // the engine sees the new size in the cycle after the write, together with the clear
    epr_back #(.POOL_BYTES(POOL_BYTES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pool_size (r_size),
        .i_cfg_clr   (r_pool_size),
        .i_cmd       (w_q_cmd),
        .i_q_empty   (w_q_empty),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_res       (w_res)
    );

    assign o_data_byte  = w_res.data_byte;
    assign o_data_valid = w_res.data_valid;
    assign o_amount     = w_res.amount;
    assign o_bytes_used = w_res.bytes_used;
    assign o_is_full    = w_res.is_full;
    assign o_last       = w_res.last;
endmodule
`default_nettype wire

[design/epr_checker.sv]
// Port-level checks of the entropy pool ring, bound to the top level.
`default_nettype none
module epr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [7:0]  o_data_byte,
    input wire logic        o_data_valid,
    input wire logic [6:0]  o_amount,
    input wire logic [6:0]  o_bytes_used,
    input wire logic        o_is_full,
    input wire logic        o_last,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] prdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_data_byte)
            && $stable(o_amount) && $stable(o_bytes_used) && $stable(o_last))
        else $error("stalled result changed");

    a_read_amount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_data_valid |-> o_amount != 7'd0)
        else $error("read byte with zero amount");

    a_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_data_valid |-> o_data_byte == 8'd0 && o_last)
        else $error("non-read result carries data or is not last");

    a_full_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_full && !paddr[2] |-> o_bytes_used == prdata[6:0])
        else $error("full ring does not hold pool_size bytes");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
endmodule

bind entropy_pool_ring epr_checker u_epr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_data_byte  (o_data_byte),
    .o_data_valid (o_data_valid),
    .o_amount     (o_amount),
    .o_bytes_used (o_bytes_used),
    .o_is_full    (o_is_full),
    .o_last       (o_last),
    .paddr        (paddr),
    .prdata       (prdata)
);
`default_nettype wire

[test/entropy_pool_ring_test.sv]
// Self-checking testbench for the entropy pool ring, predicting results from a shadow pool.
module entropy_pool_ring_test;
    timeunit 1ns;
    timeprecision 1ps;

    import epr_pkg::*;

    localparam logic [2:0] OP_UNKNOWN_LO = OP_FLUSH + 3'd1;
    localparam logic [2:0] OP_UNKNOWN_HI = 3'd7;
    localparam int SETTLE_CYCLES = 40;
    localparam int RUN_LIMIT_NS  = 8_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_operation = OP_STORE;
    logic [31:0] i_entropy_bits = '0;
    logic [5:0]  i_bit_count = '0;
    logic [6:0]  i_byte_count = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_data_byte;
    logic        o_data_valid;
    logic [6:0]  o_amount;
    logic [6:0]  o_bytes_used;
    logic        o_is_full;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow copy of the pool, updated as each transfer is accepted
    logic [7:0] shadow_bytes [POOL_BYTES_DEF] = '{default: 8'd0};
    logic [5:0] shadow_head = '0;
    logic [5:0] shadow_tail = '0;
    logic       shadow_full = 1'b0;
    logic [2:0] shadow_bit = '0;
    logic [6:0] shadow_size = 7'(POOL_BYTES_DEF);

    t_result     awaited_results [$];
    int unsigned error_count = 0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_left = 0;

    entropy_pool_ring i_dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("entropy_pool_ring_test: errors");
        $finish;
    end

    function automatic logic [6:0] shadow_used();
        if (shadow_head == shadow_tail && !shadow_full) return 7'd0;
        if (shadow_tail > shadow_head) return 7'(shadow_tail - shadow_head);
        return shadow_size - 7'(shadow_head - shadow_tail);
    endfunction

    function automatic logic [5:0] step_index(logic [5:0] idx, logic [6:0] by);
        int unsigned sum;
        sum = idx + by;
        if (sum >= shadow_size) sum -= shadow_size;
        if (sum >= shadow_size) sum = 0;
        return 6'(sum);
    endfunction

    function automatic void await_result(logic [7:0] data, logic valid, logic [6:0] amount,
                                         logic last);
        t_result r;
        r.data_byte  = data;
        r.data_valid = valid;
        r.amount     = amount;
        r.bytes_used = shadow_used();
        r.is_full    = shadow_full;
        r.last       = last;
        awaited_results.push_back(r);
    endfunction

    function automatic void shadow_set_size(logic [31:0] value);
        logic [6:0] v;
        v = value[6:0];
        if (v == 7'd0) v = 7'd1;
        if (v > POOL_BYTES_DEF) v = 7'(POOL_BYTES_DEF);
        shadow_size = v;
        shadow_head = '0;
        shadow_tail = '0;
        shadow_full = 1'b0;
        shadow_bit  = '0;
    endfunction

    function automatic void shadow_take_item(logic [2:0] op, logic [31:0] bits,
                                             logic [5:0] count_in, logic [6:0] asked);
        logic [4:0] nbits;
        logic [6:0] held;
        logic [6:0] take;
        logic [7:0] head_byte;
        int k;
        nbits = count_in[4:0];
        case (op)
            OP_STORE: begin
                for (k = 0; k < nbits; k++) begin
                    shadow_bytes[shadow_tail][shadow_bit] ^= bits[k];
                    shadow_bit++;
                    if (shadow_bit == 3'd0) begin
                        // a full ring loses its oldest byte
                        if (shadow_full) shadow_head = step_index(shadow_head, 7'd1);
                        shadow_tail = step_index(shadow_tail, 7'd1);
                        shadow_full = (shadow_tail == shadow_head);
                    end
                end
                await_result(8'd0, 1'b0, 7'(nbits), 1'b1);
            end
            OP_READ_ONE: begin
                if (shadow_used() == 7'd0) begin
                    await_result(8'd0, 1'b0, 7'd0, 1'b1);
                end else begin
                    head_byte = shadow_bytes[shadow_head];
                    shadow_head = step_index(shadow_head, 7'd1);
                    shadow_full = 1'b0;
                    await_result(head_byte, 1'b1, 7'd1, 1'b1);
                end
            end
            OP_READ_MANY: begin
                held = shadow_used();
                take = (asked < held) ? asked : held;
                if (take > MAX_READ) take = MAX_READ;
                if (take == 7'd0) begin
                    await_result(8'd0, 1'b0, 7'd0, 1'b1);
                end else begin
                    for (k = 0; k < take; k++) begin
                        head_byte = shadow_bytes[shadow_head];
                        shadow_head = step_index(shadow_head, 7'd1);
                        shadow_full = 1'b0;
                        await_result(head_byte, 1'b1, take, (k + 1 == take));
                    end
                end
            end
            OP_DISCARD: begin
                held = shadow_used();
                take = (asked < held) ? asked : held;
                shadow_head = step_index(shadow_head, take);
                if (take != 7'd0) shadow_full = 1'b0;
                await_result(8'd0, 1'b0, take, 1'b1);
            end
            OP_FLUSH: begin
                // bit position survives a flush
                shadow_head = '0;
                shadow_tail = '0;
                shadow_full = 1'b0;
                await_result(8'd0, 1'b0, 7'd0, 1'b1);
            end
            default: begin
                await_result(8'd0, 1'b0, 7'd0, 1'b1);
            end
        endcase
    endfunction

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        error_count++;
    endtask

    always @(posedge i_clk) begin : check_result
        t_result seen;
        t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            seen = {o_data_byte, o_data_valid, o_amount, o_bytes_used, o_is_full, o_last};
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, seen);
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                if (seen.data_byte !== want.data_byte)
                    report_mismatch("data_byte", want.data_byte, seen.data_byte);
                if (seen.data_valid !== want.data_valid)
                    report_mismatch("data_valid", want.data_valid, seen.data_valid);
                if (seen.amount !== want.amount)
                    report_mismatch("amount", want.amount, seen.amount);
                if (seen.bytes_used !== want.bytes_used)
                    report_mismatch("bytes_used", want.bytes_used, seen.bytes_used);
                if (seen.is_full !== want.is_full)
                    report_mismatch("is_full", want.is_full, seen.is_full);
                if (seen.last !== want.last)
                    report_mismatch("last", want.last, seen.last);
            end
        end
    end

    // receiver: a long hold-off takes precedence over random stalls
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_item(logic [2:0] op, logic [31:0] bits, logic [5:0] nbits,
                             logic [6:0] nbytes);
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_entropy_bits <= bits;
        i_bit_count    <= nbits;
        i_byte_count   <= nbytes;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        shadow_take_item(op, bits, nbits, nbytes);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_pool_size(logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * CFG_POOL_SIZE);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        shadow_set_size(value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_random_items(int unsigned n, int unsigned store_pct);
        int unsigned roll;
        logic [2:0] op;
        logic [6:0] nbytes;
        repeat (n) begin
            roll = $urandom_range(99);
            if (roll < store_pct) begin
                op = OP_STORE;
            end else begin
                roll = $urandom_range(99);
                if (roll < 35) op = OP_READ_ONE;
                else if (roll < 65) op = OP_READ_MANY;
                else if (roll < 80) op = OP_DISCARD;
                else if (roll < 88) op = OP_FLUSH;
                else op = 3'($urandom_range(OP_UNKNOWN_HI, OP_UNKNOWN_LO));
            end
            nbytes = $urandom_range(1) ? 7'($urandom_range(8)) : 7'($urandom_range(127));
            send_item(op, $urandom, 6'($urandom_range(63)), nbytes);
        end
    endtask

    task automatic test_empty_ring();
        logic [2:0] op;
        send_item(OP_READ_ONE, 32'h0, 6'd0, 7'd0);
        send_item(OP_READ_MANY, 32'h0, 6'd0, 7'd127);
        send_item(OP_DISCARD, 32'h0, 6'd0, 7'd127);
        send_item(OP_FLUSH, 32'h0, 6'd0, 7'd0);
        for (op = OP_UNKNOWN_LO; op != OP_STORE; op++)
            send_item(op, 32'hFFFF_FFFF, 6'd63, 7'd127);
        // a count of 32 wraps to no bits at all
        send_item(OP_STORE, 32'hFFFF_FFFF, 6'd32, 7'd0);
        drain_results();
    endtask

    task automatic test_store_extremes();
        send_item(OP_STORE, 32'hFFFF_FFFF, 6'd63, 7'd127);
        send_item(OP_STORE, 32'h0000_0000, 6'd31, 7'd0);
        send_item(OP_STORE, 32'h5A5A_5A5A, 6'd33, 7'd64);
        send_item(OP_STORE, 32'hA5A5_A5A5, 6'd8, 7'd1);
        send_item(OP_READ_ONE, 32'h0, 6'd0, 7'd0);
        send_item(OP_READ_MANY, 32'h0, 6'd0, 7'd2);
        send_item(OP_DISCARD, 32'h0, 6'd0, 7'd1);
        send_item(OP_READ_MANY, 32'h0, 6'd0, 7'd127);
        // leave a partial byte, flush, then finish it
        send_item(OP_STORE, 32'h0000_0007, 6'd3, 7'd0);
        send_item(OP_FLUSH, 32'h0, 6'd0, 7'd0);
        send_item(OP_STORE, 32'h0000_01FF, 6'd9, 7'd0);
        send_item(OP_READ_MANY, 32'h0, 6'd0, 7'd64);
        drain_results();
    endtask

    task automatic test_tiny_ring();
        // zero is clamped up to a single byte
        write_pool_size({25'($urandom), 7'd0});
        send_item(OP_STORE, 32'hFFFF_FFFF, 6'd31, 7'd0);
        send_item(OP_READ_ONE, 32'h0, 6'd0, 7'd0);
        send_item(OP_STORE, 32'h0000_1234, 6'd16, 7'd0);
        send_item(OP_READ_MANY, 32'h0, 6'd0, 7'd5);
        drain_results();
        // out of range is clamped down to the whole pool
        write_pool_size({25'($urandom), 7'h7F});
    endtask

    task automatic test_fill_and_wrap();
        gap_pct = 0;
        stall_pct = 0;
        send_random_items(80, 85);
        drain_results();
    endtask

    task automatic test_sender_gaps();
        write_pool_size($urandom_range(16, 2));
        gap_pct = 54;
        stall_pct = 0;
        send_random_items(80, 55);
        drain_results();
    endtask

    task automatic test_receiver_stalls();
        write_pool_size($urandom_range(63, 17));
        gap_pct = 0;
        stall_pct = 54;
        send_random_items(80, 60);
        drain_results();
    endtask

    task automatic test_mixed_idling();
        write_pool_size(32'd64);
        gap_pct = 8;
        stall_pct = 8;
        send_random_items(80, 70);
        drain_results();
    endtask

    task automatic test_output_backpressure();
        write_pool_size($urandom_range(40, 24));
        gap_pct = 0;
        stall_pct = 0;
        // hold the output long enough for the input to back up
        hold_left = 300;
        send_random_items(24, 50);
        drain_results();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_ring();
        test_store_extremes();
        test_tiny_ring();
        test_fill_and_wrap();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        test_output_backpressure();

        drain_results();
        if (error_count == 0) begin
            $display("entropy_pool_ring_test: clean");
        end else begin
            $display("entropy_pool_ring_test: errors");
        end
        $finish;
    end

endmodule

[files.f]
design/epr_pkg.sv
design/epr_ram.sv
design/epr_front.sv
design/epr_queue.sv
design/epr_back.sv
design/entropy_pool_ring.sv
design/epr_checker.sv
test/entropy_pool_ring_test.sv
